>>> hw/rtl/pfan_pkg.sv
// Package for the polygon face area normal unit.
// Holds widths, queue sizing and the types shared by the front, queue and back.
// No dependencies.
package pfan_pkg;

   // Coordinate format: signed fixed point with 12 fraction bits.
   localparam int COORD_BITS        = 24;
   localparam int MAX_FACE_VERTICES = 64;
   localparam int SUM_BITS          = 56;

   // Derived arithmetic widths.
   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int TERM_BITS = PROD_BITS + 2;

   // The vertex count saturates at MAX_FACE_VERTICES + 1.
   localparam int CNT_BITS = $clog2(MAX_FACE_VERTICES + 2);

   // Work queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vert_type;

   // One classified vertex, ready for the arithmetic back end.
   typedef struct packed {
      vert_type prev;       // previous vertex of the face
      vert_type cur;        // this vertex
      vert_type first;      // first vertex of the face (this vertex if it starts one)
      logic     pair;       // a previous vertex exists, so prev x cur is added
      logic     last;       // face closes here, so cur x first is added
      logic     too_long;   // face has more vertices than supported
   } work_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> hw/rtl/pfan_if.sv
// Channel interfaces for the polygon face area normal unit.
// Depends on pfan_pkg for the coordinate and sum widths.
interface pfan_req_if import pfan_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   coord_type vertex_z;
   logic      last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                   output last_vertex, input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                   input last_vertex, output ready);
endinterface

interface pfan_rsp_if import pfan_pkg::*; ();
   logic    valid;
   logic    ready;
   sum_type normal_x;
   sum_type normal_y;
   sum_type normal_z;
   logic    face_too_long;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output face_too_long, input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input face_too_long, output ready);
endinterface

>>> hw/rtl/pfan_front.sv
// Front end: accepts vertex words, tracks first and previous vertex and the count.
// Depends on pfan_pkg and pfan_req_if; feeds pfan_queue.
module pfan_front import pfan_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   pfan_req_if.sink       req_chan,
   input  qstat_type      qstat,
   output logic           push,
   output work_type       push_work
);

   vert_type             first_ff, first_in;
   vert_type             prev_ff, prev_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  count_inc;
   logic                 accept;
   logic                 face_start;
   vert_type             cur;

   assign req_chan.ready = !qstat.full;
   assign accept         = req_chan.valid && !qstat.full;
   assign face_start     = (count_ff == '0);

   assign cur.x = req_chan.vertex_x;
   assign cur.y = req_chan.vertex_y;
   assign cur.z = req_chan.vertex_z;

   // Saturating vertex count.
   always_comb begin
      if (count_ff <= CNT_BITS'(MAX_FACE_VERTICES)) begin
         count_inc = count_ff + CNT_BITS'(1);
      end else begin
         count_inc = count_ff;
      end
   end

   // Next-state for the face tracking registers.
   always_comb begin
      first_in = first_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      if (accept) begin
         prev_in = cur;
         if (face_start) begin
            first_in = cur;
         end
         if (req_chan.last_vertex) begin
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   // Classified word toward the back end.
   always_comb begin
      push               = accept;
      push_work.prev     = prev_ff;
      push_work.cur      = cur;
      push_work.first    = face_start ? cur : first_ff;
      push_work.pair     = !face_start;
      push_work.last     = req_chan.last_vertex;
      push_work.too_long = (count_inc > CNT_BITS'(MAX_FACE_VERTICES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
      end else begin
         first_ff <= first_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   // A closing vertex always leaves the next vertex starting a new face.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_vertex |=> count_ff == '0)
      else $error("vertex count not cleared after face end");
`endif

endmodule

>>> hw/rtl/pfan_queue.sv
// Short work queue that decouples the front end from the arithmetic back end.
// Depends on pfan_pkg.
module pfan_queue import pfan_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  work_type  push_work,
   input  logic      pop,
   output work_type  head_work,
   output qstat_type qstat
);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_work   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_work;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_BITS'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with occupancy");
`endif

endmodule

>>> hw/rtl/pfan_back.sv
// Back end: cross products, accumulation and the result register.
// Depends on pfan_pkg and pfan_rsp_if; drains pfan_queue.
module pfan_back import pfan_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  work_type   head_work,
   input  qstat_type  qstat,
   output logic       pop,
   pfan_rsp_if.source rsp_chan
);

   // Stage A: twelve products, pair terms and closing terms.
   prod_type  pp_ff [6];
   prod_type  cp_ff [6];
   logic      a_vld_ff, a_pair_ff, a_last_ff, a_long_ff;

   // Stage B: per-axis contribution of one vertex.
   sum_type   term_ff [3];
   sum_type   term_in [3];
   logic      b_vld_ff, b_last_ff, b_long_ff;

   // Stage C: accumulators and the result word.
   sum_type   sum_ff [3];
   sum_type   sum_in [3];
   sum_type   total [3];
   sum_type   out_ff [3];
   logic      rsp_valid_ff, rsp_valid_in;
   logic      long_ff;

   logic      adv;
   logic signed [TERM_BITS-1:0] pdiff [3];
   logic signed [TERM_BITS-1:0] cdiff [3];

   // The whole back pipeline moves when the result register can take a word.
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign pop = adv && !qstat.empty;

   // Stage A products: prev x cur and cur x first.
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= head_work.prev.y * head_work.cur.z;
         pp_ff[1] <= head_work.prev.z * head_work.cur.y;
         pp_ff[2] <= head_work.prev.z * head_work.cur.x;
         pp_ff[3] <= head_work.prev.x * head_work.cur.z;
         pp_ff[4] <= head_work.prev.x * head_work.cur.y;
         pp_ff[5] <= head_work.prev.y * head_work.cur.x;
         cp_ff[0] <= head_work.cur.y * head_work.first.z;
         cp_ff[1] <= head_work.cur.z * head_work.first.y;
         cp_ff[2] <= head_work.cur.z * head_work.first.x;
         cp_ff[3] <= head_work.cur.x * head_work.first.z;
         cp_ff[4] <= head_work.cur.x * head_work.first.y;
         cp_ff[5] <= head_work.cur.y * head_work.first.x;
         a_pair_ff <= head_work.pair;
         a_last_ff <= head_work.last;
         a_long_ff <= head_work.too_long;
      end
   end

   // Stage B: differences, gated by which cross terms apply to this vertex.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pdiff[i] = TERM_BITS'(pp_ff[2*i]) - TERM_BITS'(pp_ff[2*i+1]);
         cdiff[i] = TERM_BITS'(cp_ff[2*i]) - TERM_BITS'(cp_ff[2*i+1]);
         if (!a_pair_ff) begin
            pdiff[i] = '0;
         end
         if (!a_last_ff) begin
            cdiff[i] = '0;
         end
         term_in[i] = SUM_BITS'(pdiff[i] + cdiff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff   <= term_in;
         b_last_ff <= a_last_ff;
         b_long_ff <= a_long_ff;
      end
   end

   // Stage C: accumulate; a closing vertex emits the total and clears the sums.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         total[i]  = sum_ff[i] + term_ff[i];
         sum_in[i] = sum_ff[i];
         if (adv && b_vld_ff) begin
            sum_in[i] = b_last_ff ? '0 : total[i];
         end
      end
      rsp_valid_in = adv ? (b_vld_ff && b_last_ff) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && b_vld_ff && b_last_ff) begin
         out_ff  <= total;
         long_ff <= b_long_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '{default: '0};
      end else begin
         if (adv) begin
            a_vld_ff <= pop;
            b_vld_ff <= a_vld_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.normal_x      = out_ff[0];
   assign rsp_chan.normal_y      = out_ff[1];
   assign rsp_chan.normal_z      = out_ff[2];
   assign rsp_chan.face_too_long = long_ff;

`ifndef SYNTHESIS
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      adv && b_vld_ff && b_last_ff |=>
         sum_ff[0] == '0 && sum_ff[1] == '0 && sum_ff[2] == '0)
      else $error("accumulators not cleared after face end");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_vld_ff && b_last_ff))
      else $error("result word raised without a closing vertex");
`endif

endmodule

>>> hw/rtl/polygon_face_area_normal_unit.sv
// Top level of the polygon face area normal unit (Newell area vector per face).
// Depends on pfan_pkg, pfan_if, pfan_front, pfan_queue and pfan_back.
//
//   channel   | dir | handshake            | word
//   ----------+-----+----------------------+---------------------------------------
//   req_chan  | in  | valid/ready          | vertex_x/y/z, last_vertex
//   rsp_chan  | out | valid/ready          | normal_x/y/z, face_too_long
//
// While the queue has room, one vertex word is taken per cycle; twelve multiplies per word
// (prev x cur and cur x first) run in parallel, so throughput is one vertex per clock.
// A face result passes through the queue, stage A, stage B and the result register.
// Reset is synchronous and clears counts, sums and valid flags; there is no clearing pass.
// When rsp_chan stalls the back end holds; the four-word queue keeps req_chan
// ready until it fills.
module polygon_face_area_normal_unit import pfan_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfan_req_if.sink   req_chan,
   pfan_rsp_if.source rsp_chan
);

   qstat_type qstat;
   logic      push;
   logic      pop;
   work_type  push_work;
   work_type  head_work;

   pfan_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .qstat     (qstat),
      .push      (push),
      .push_work (push_work)
   );

   pfan_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .head_work (head_work),
      .qstat     (qstat)
   );

   pfan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_work (head_work),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> tb/sv/pfan_area_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the polygon face area normal unit. It predicts each face's
// area vector from the accepted vertex words and compares it with the result words.
// Depends on pfan_pkg and the channel interfaces in pfan_if.
module pfan_area_checker import pfan_pkg::*; (
   input  logic clock,
   input  logic reset,
   pfan_req_if  req_mon,
   pfan_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   faces_pending
);

   typedef struct packed {
      sum_type normal_x;
      sum_type normal_y;
      sum_type normal_z;
      logic    too_long;
   } area_word_type;

   // Predicted area words, oldest first.
   area_word_type area_queue[$];

   // Running state of the face being streamed.
   vert_type    face_first;
   vert_type    face_prev;
   sum_type     acc_x;
   sum_type     acc_y;
   sum_type     acc_z;
   int unsigned face_count;
   int          faces_checked;

   // One component of a cross product, a*b - c*d, reduced to the sum width.
   function automatic sum_type cross_part(input coord_type a, b, c, d);
      longint ab;
      longint cd;
      ab = longint'(a) * longint'(b);
      cd = longint'(c) * longint'(d);
      return sum_type'(ab - cd);
   endfunction

   // Accumulate u x v into the face sums; wraps at the sum width.
   function automatic void add_cross(input vert_type u, input vert_type v);
      acc_x = acc_x + cross_part(u.y, v.z, u.z, v.y);
      acc_y = acc_y + cross_part(u.z, v.x, u.x, v.z);
      acc_z = acc_z + cross_part(u.x, v.y, u.y, v.x);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns face %0d: %s got %0d, expected %0d",
               $time, faces_checked, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      area_word_type got;
      area_word_type want;
      vert_type      cur;
      if (reset) begin
         face_first = '0;
         face_prev  = '0;
         acc_x      = '0;
         acc_y      = '0;
         acc_z      = '0;
         face_count = 0;
         area_queue.delete();
      end else begin
         // Compare a result word with the oldest predicted area.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.normal_x, rsp_mon.normal_y, rsp_mon.normal_z,
                    rsp_mon.face_too_long};
            if (area_queue.size() == 0) begin
               report_mismatch("result word with no face pending, normal_x", got.normal_x, 0);
            end else begin
               want = area_queue.pop_front();
               if (got.normal_x !== want.normal_x)
                  report_mismatch("normal_x", got.normal_x, want.normal_x);
               if (got.normal_y !== want.normal_y)
                  report_mismatch("normal_y", got.normal_y, want.normal_y);
               if (got.normal_z !== want.normal_z)
                  report_mismatch("normal_z", got.normal_z, want.normal_z);
               if (got.too_long !== want.too_long)
                  report_mismatch("face_too_long", got.too_long, want.too_long);
            end
            faces_checked++;
         end

         // Fold an accepted vertex word into the running face.
         if (req_mon.valid && req_mon.ready) begin
            cur = '{req_mon.vertex_x, req_mon.vertex_y, req_mon.vertex_z};
            if (face_count == 0)
               face_first = cur;
            else
               add_cross(face_prev, cur);
            face_prev = cur;
            if (face_count <= MAX_FACE_VERTICES)
               face_count++;

            // The last vertex closes the loop back to the first one.
            if (req_mon.last_vertex) begin
               add_cross(cur, face_first);
               want = '{acc_x, acc_y, acc_z, (face_count > MAX_FACE_VERTICES)};
               area_queue.push_back(want);
               acc_x      = '0;
               acc_y      = '0;
               acc_z      = '0;
               face_count = 0;
            end
         end
      end
      faces_pending = area_queue.size();
   end

endmodule

>>> tb/sv/polygon_face_area_normal_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the polygon face area normal unit: drives vertex words and
// result backpressure, and gives the verdict. Depends on pfan_pkg, pfan_if,
// pfan_area_checker and the unit itself.
module polygon_face_area_normal_unit_tb;
   import pfan_pkg::*;

   typedef enum int unsigned {
      COORD_FULL,
      COORD_NEAR_ZERO,
      COORD_CORNER
   } coord_style_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam coord_type COORD_ONE = coord_type'(4096);
   localparam int        MIN_VERTICES = 560;
   localparam int        MIN_FACES    = 40;
   localparam int        SPIRAL_LEN   = 100;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   faces_pending;

   bit   idle_on;
   int   vertices_sent;
   int   faces_sent;
   int   overlong_faces;
   int   longest_face;
   int   cur_face_len;

   pfan_req_if req_chan ();
   pfan_rsp_if rsp_chan ();

   polygon_face_area_normal_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pfan_area_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .faces_pending  (faces_pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #20_000_000;
      $display("Timeout: the unit stopped taking or returning words");
      $display("Mismatches found");
      $finish;
   end

   // Result side: ready drops in random bursts while idling is enabled.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (idle_on && stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
               stall_left = $urandom_range(1, 17);
         end
         @(negedge clock);
      end
   end

   function automatic coord_type rand_coord(input coord_style_type style);
      case (style)
         COORD_FULL: begin
            return coord_type'($urandom);
         end
         COORD_NEAR_ZERO: begin
            return coord_type'($urandom_range(0, 8192)) - COORD_ONE;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               3:       return '1;
               default: return coord_type'(1);
            endcase
         end
      endcase
   endfunction

   // Sends one vertex word; entered and left at a falling edge, valid left high.
   task automatic send_vertex(input coord_type vx, vy, vz, input logic is_last);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= vx;
      req_chan.vertex_y    <= vy;
      req_chan.vertex_z    <= vz;
      req_chan.last_vertex <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      vertices_sent++;
      cur_face_len++;
      if (is_last) begin
         faces_sent++;
         if (cur_face_len > MAX_FACE_VERTICES)
            overlong_faces++;
         if (cur_face_len > longest_face)
            longest_face = cur_face_len;
         cur_face_len = 0;
      end
   endtask

   task automatic send_random_face(input int len, input coord_style_type style);
      for (int i = 0; i < len; i++)
         send_vertex(rand_coord(style), rand_coord(style), rand_coord(style), i == len - 1);
   endtask

   // A long face winding around the x axis at full scale.
   task automatic send_spiral(input int len);
      coord_type vy;
      coord_type vz;
      for (int i = 0; i < len; i++) begin
         case (i % 4)
            0:       begin vy = COORD_MAX; vz = '0;        end
            1:       begin vy = '0;        vz = COORD_MAX; end
            2:       begin vy = COORD_MIN; vz = '0;        end
            default: begin vy = '0;        vz = COORD_MIN; end
         endcase
         send_vertex('0, vy, vz, i == len - 1);
      end
   endtask

   task automatic wait_for_results();
      while (faces_pending != 0) @(negedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      int pick;
      int len;
      reset                = 1'b1;
      idle_on              = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.vertex_x    = '0;
      req_chan.vertex_y    = '0;
      req_chan.vertex_z    = '0;
      req_chan.last_vertex = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-vertex faces at both extremes give a zero vector.
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      // A two-vertex face cancels to zero.
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      // Triangles on the axes at full scale, both signs.
      send_vertex(COORD_MAX, '0, '0, 1'b0);
      send_vertex('0, COORD_MAX, '0, 1'b0);
      send_vertex('0, '0, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, '0, '0, 1'b0);
      send_vertex('0, COORD_MIN, '0, 1'b0);
      send_vertex('0, '0, COORD_MIN, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, '0, 1'b0);
      send_vertex('0, COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, '0, COORD_MAX, 1'b1);
      // Unit square in the xy plane.
      send_vertex('0, '0, '0, 1'b0);
      send_vertex(COORD_ONE, '0, '0, 1'b0);
      send_vertex(COORD_ONE, COORD_ONE, '0, 1'b0);
      send_vertex('0, COORD_ONE, '0, 1'b1);
      // Quad on mixed extremes.
      send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);

      // Let the unit drain completely before the random part.
      req_chan.valid <= 1'b0;
      wait_for_results();

      // Faces right at and just past the supported length, then a long full-scale one.
      send_random_face(MAX_FACE_VERTICES, COORD_FULL);
      send_random_face(MAX_FACE_VERTICES + 1, COORD_CORNER);
      send_spiral(SPIRAL_LEN);

      // Random faces, mostly short, with idling switched on and off in stretches.
      while (vertices_sent < MIN_VERTICES || faces_sent < MIN_FACES) begin
         if (faces_sent % 8 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 199);
         if (pick < 140)
            len = $urandom_range(1, 8);
         else if (pick < 190)
            len = $urandom_range(9, 24);
         else if (pick < 196)
            len = $urandom_range(60, 70);
         else
            len = $urandom_range(100, 140);
         send_random_face(len, coord_style_type'($urandom_range(0, 2)));
      end

      // Closing stretch at full rate on both sides.
      idle_on = 1'b0;
      repeat (25) send_random_face($urandom_range(1, 6), COORD_FULL);
      req_chan.valid <= 1'b0;

      wait_for_results();
      repeat (10) @(negedge clock);

      $display("Sent %0d vertex words in %0d faces; %0d faces overlong, longest %0d vertices.",
               vertices_sent, faces_sent, overlong_faces, longest_face);
      $display("Faces covered degenerate, axis-aligned, extreme, random and overlong shapes.");
      if (mismatch_count == 0 && faces_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pfan_pkg.sv
hw/rtl/pfan_if.sv
hw/rtl/pfan_front.sv
hw/rtl/pfan_queue.sv
hw/rtl/pfan_back.sv
hw/rtl/polygon_face_area_normal_unit.sv
tb/sv/pfan_area_checker.sv
tb/sv/polygon_face_area_normal_unit_tb.sv
